### sv/tec_pkg.sv
// Shared types, token tables and constants for the text escape codec.
// No dependencies; imported by every module of the codec.
package tec_pkg;

   localparam int TOKEN_COUNT = 6;
   localparam int WINDOW_MAX  = 5;
   localparam int PEND_MAX    = 4;
   localparam int CNT_W       = 3;

   typedef enum logic [1:0] {
      MODE_HTML_ESC   = 2'd0,
      MODE_HTML_UNESC = 2'd1,
      MODE_SQL_ESC    = 2'd2,
      MODE_PASS       = 2'd3
   } mode_type;

   typedef logic [0:WINDOW_MAX-1][7:0] window_type;

   typedef struct packed {
      window_type         data;
      logic [CNT_W-1:0]   cnt;
      logic               last;
   } entry_type;

   localparam logic [7:0] CHAR_AMP   = 8'h26;
   localparam logic [7:0] CHAR_LT    = 8'h3c;
   localparam logic [7:0] CHAR_BSL   = 8'h5c;
   localparam logic [7:0] CHAR_DQUOT = 8'h22;
   localparam logic [7:0] CHAR_SQUOT = 8'h27;

   localparam window_type TOK_TEXT [TOKEN_COUNT] = '{
      '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b},
      '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00},
      '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00},
      '{8'h26, 8'h23, 8'h33, 8'h34, 8'h3b},
      '{8'h26, 8'h23, 8'h33, 8'h39, 8'h3b},
      '{8'h3c, 8'h62, 8'h72, 8'h2f, 8'h3e}
   };

   localparam logic [CNT_W-1:0] TOK_LEN [TOKEN_COUNT] = '{
      3'd5, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5
   };

   localparam logic [7:0] TOK_CHAR [TOKEN_COUNT] = '{
      8'h26, 8'h3c, 8'h3e, 8'h22, 8'h27, 8'h0a
   };

endpackage

### sv/tec_front.sv
// Front end of the codec: accepts request bytes, matches tokens, builds queue entries.
// Holds the partial-token window for unescape. Depends on tec_pkg.
module tec_front import tec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  mode_type   mode,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   input  logic       q_full,
   output logic       push,
   output entry_type  entry
);

   logic [7:0]       pend_ff [PEND_MAX];
   logic [7:0]       pend_in [PEND_MAX];
   logic [CNT_W-1:0] pend_cnt_ff;
   logic [CNT_W-1:0] pend_cnt_in;
   logic [CNT_W-1:0] held;
   logic [CNT_W-1:0] wl;
   window_type       win;
   logic             fire;
   logic             full_any;
   logic             prefix_any;
   logic             hold_b;
   logic [7:0]       full_char;
   logic [TOKEN_COUNT-1:0] tok_hit;

   assign req_ready = !q_full;
   assign fire      = req_valid && req_ready;
   assign held      = pend_cnt_ff;
   assign wl        = pend_cnt_ff + 3'd1;
   assign hold_b    = (req_in_byte == CHAR_AMP || req_in_byte == CHAR_LT) && !req_in_last;

   always_comb begin
      for (int i = 0; i < PEND_MAX; i++) begin
         if (3'(i) < held) begin
            win[i] = pend_ff[i];
         end else if (3'(i) == held) begin
            win[i] = req_in_byte;
         end else begin
            win[i] = 8'h00;
         end
      end
      win[WINDOW_MAX-1] = (held == 3'(PEND_MAX)) ? req_in_byte : 8'h00;
   end

   always_comb begin
      full_any   = 1'b0;
      prefix_any = 1'b0;
      full_char  = 8'h00;
      for (int t = 0; t < TOKEN_COUNT; t++) begin
         tok_hit[t] = (wl <= TOK_LEN[t]);
         for (int i = 0; i < WINDOW_MAX; i++) begin
            if (3'(i) < wl && win[i] != TOK_TEXT[t][i]) begin
               tok_hit[t] = 1'b0;
            end
         end
         if (tok_hit[t] && wl == TOK_LEN[t]) begin
            full_any  = 1'b1;
            full_char = TOK_CHAR[t];
         end
         if (tok_hit[t] && wl < TOK_LEN[t]) begin
            prefix_any = 1'b1;
         end
      end
   end

   always_comb begin
      entry.data  = '0;
      entry.cnt   = 3'd1;
      entry.last  = req_in_last;
      pend_cnt_in = pend_cnt_ff;
      for (int i = 0; i < PEND_MAX; i++) begin
         pend_in[i] = pend_ff[i];
      end
      entry.data[0] = req_in_byte;
      unique case (mode)
         MODE_HTML_ESC: begin
            for (int t = 0; t < TOKEN_COUNT; t++) begin
               if (TOK_CHAR[t] == req_in_byte) begin
                  entry.data = TOK_TEXT[t];
                  entry.cnt  = TOK_LEN[t];
               end
            end
         end
         MODE_SQL_ESC: begin
            if (req_in_byte == CHAR_BSL || req_in_byte == CHAR_DQUOT ||
                req_in_byte == CHAR_SQUOT) begin
               entry.data[0] = CHAR_BSL;
               entry.data[1] = req_in_byte;
               entry.cnt     = 3'd2;
            end
         end
         MODE_HTML_UNESC: begin
            pend_cnt_in = '0;
            if (full_any) begin
               entry.data[0] = full_char;
            end else if (prefix_any && !req_in_last) begin
               entry.cnt   = '0;
               pend_cnt_in = wl;
               for (int i = 0; i < PEND_MAX; i++) begin
                  pend_in[i] = win[i];
               end
            end else if (prefix_any) begin
               entry.data = win;
               entry.cnt  = wl;
            end else if (hold_b) begin
               entry.data  = win;
               entry.cnt   = held;
               pend_cnt_in = 3'd1;
               pend_in[0]  = req_in_byte;
            end else begin
               entry.data = win;
               entry.cnt  = wl;
            end
         end
         MODE_PASS: begin
            entry.cnt = 3'd1;
         end
         default: begin
            entry.cnt = 3'd1;
         end
      endcase
   end

   assign push = fire && (entry.cnt != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_cnt_ff <= '0;
      end else if (fire && mode == MODE_HTML_UNESC) begin
         pend_cnt_ff <= pend_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && mode == MODE_HTML_UNESC) begin
         for (int i = 0; i < PEND_MAX; i++) begin
            pend_ff[i] <= pend_in[i];
         end
      end
   end

endmodule

### sv/tec_queue.sv
// Short entry queue between the codec front end and the serialiser.
// Depends on tec_pkg for the entry type.
module tec_queue import tec_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   input  logic      pop,
   output logic      full,
   output logic      head_valid,
   output entry_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W_Q = $clog2(DEPTH + 1);

   entry_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W_Q-1:0] cnt_ff, cnt_in;
   logic               do_push;
   logic               do_pop;

   assign full       = (cnt_ff == CNT_W_Q'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W_Q'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W_Q'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### sv/tec_back.sv
// Back end of the codec: walks the head entry byte by byte into the response register.
// Depends on tec_pkg for the entry type.
module tec_back import tec_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  entry_type  head,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_last
);

   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;
   logic             load;
   logic             at_end;

   assign load   = head_valid && (!valid_ff || rsp_ready);
   assign at_end = ((idx_ff + 3'd1) == head.cnt);
   assign pop    = load && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff && !rsp_ready;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = head.data[idx_ff];
         last_in  = head.last && at_end;
         idx_in   = at_end ? '0 : idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_out_last = last_ff;

endmodule

### sv/text_escape_codec_core.sv
// Top level of the text escape codec: mode register, front end, queue and serialiser.
// Depends on tec_pkg, tec_front, tec_queue and tec_back.
//
// Usage:
//   Request channel (req_valid/req_ready) carries one text byte per request with
//   req_in_last marking the end of the text. Response channel (rsp_valid/rsp_ready)
//   returns the rewritten bytes; rsp_out_last is set on the final byte produced by a
//   request that had req_in_last set.
//   The mode register at byte address 0 of the APB port selects html escape (0),
//   html unescape (1), sql backslash escape (2) or pass-through (3). Write it only
//   while no request is in flight.
//   The first byte of a request passes through the queue and then the response
//   register before it shows on rsp_valid. One request is accepted per cycle while
//   the queue has room; the serialiser emits one byte per cycle while rsp_ready is
//   high, and the queue absorbs the difference while a request expands into N bytes.
//   Unescape may hold up to four bytes of a partial token and give nothing for them
//   until the token completes, fails or the last byte arrives.
//   Reset clears the mode to 0, empties the queue and drops any held partial token.
//   A stalled receiver fills the queue, after which req_ready drops until it drains.
module text_escape_codec_core import tec_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_in_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_out_last,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   mode_type  mode_ff, mode_in;
   logic      csr_wr;
   logic      q_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
   assign mode_in = csr_wr ? mode_type'(pwdata[1:0]) : mode_ff;
   assign prdata = (paddr[2] == 1'b0) ? {30'b0, mode_ff} : 32'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_HTML_ESC;
      end else begin
         mode_ff <= mode_in;
      end
   end

   tec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .mode        (mode_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .q_full      (q_full),
      .push        (push),
      .entry       (push_entry)
   );

   tec_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head       (head)
   );

   tec_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_valid   (head_valid),
      .head         (head),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_byte (rsp_out_byte),
      .rsp_out_last (rsp_out_last)
   );

endmodule

### sv/tec_checker.sv
// Port-level checks for the text escape codec, bound to text_escape_codec_core.
// No package dependency; sees the top-level ports only.
module tec_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_last,
   input logic       pready
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_last))
      else $error("response changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("response or backpressure present after reset");

   a_pready: assert property (@(posedge clock) pready)
      else $error("pready low");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with no response pending");

endmodule

bind text_escape_codec_core tec_checker u_tec_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last),
   .pready       (pready)
);
